>>> rtl/core/pxsd_pkg.sv
package pxsd_pkg;

    // Key and checksum masks
    localparam logic [7:0] KEY_MASK = 8'hCC;
    localparam logic [7:0] SUM_MASK = 8'hAA;

    // One received word
    typedef struct packed {
        logic [7:0]  in_byte;
        logic        first_of_packet;
        logic        last_of_packet;
        logic [15:0] port;
    } t_in_word;

    // One descrambled word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       packet_end;
        logic       checksum_ok;
    } t_out_word;

    // Fixed byte substitution
    localparam logic [7:0] SBOX_TABLE [0:255] = '{
        8'hB4, 8'h62, 8'h07, 8'hE5, 8'h9D, 8'hAF, 8'h63, 8'hDD,
        8'hE3, 8'hD0, 8'hCC, 8'hFE, 8'hDC, 8'hDB, 8'h6B, 8'h2E,
        8'h6A, 8'h40, 8'hAB, 8'h47, 8'hC9, 8'hD1, 8'h53, 8'hD5,
        8'h20, 8'h91, 8'hA5, 8'h0E, 8'h4A, 8'hDF, 8'h18, 8'h89,
        8'hFD, 8'h6F, 8'h25, 8'h12, 8'hB7, 8'h13, 8'h77, 8'h00,
        8'h65, 8'h36, 8'h6D, 8'h49, 8'hEC, 8'h57, 8'h2A, 8'hA9,
        8'h11, 8'h5F, 8'hFA, 8'h78, 8'h95, 8'hA4, 8'hBD, 8'h1E,
        8'hD9, 8'h79, 8'h44, 8'hCD, 8'hDE, 8'h81, 8'hEB, 8'h09,
        8'h3E, 8'hF6, 8'hEE, 8'hDA, 8'h7F, 8'hA3, 8'h1A, 8'hA7,
        8'h2D, 8'hA6, 8'hAD, 8'hC1, 8'h46, 8'h93, 8'hD2, 8'h1B,
        8'h9C, 8'hAA, 8'hD7, 8'h4E, 8'h4B, 8'h4D, 8'h4C, 8'hF3,
        8'hB8, 8'h34, 8'hC0, 8'hCA, 8'h88, 8'hF4, 8'h94, 8'hCB,
        8'h04, 8'h39, 8'h30, 8'h82, 8'hD6, 8'h73, 8'hB0, 8'hBF,
        8'h22, 8'h01, 8'h41, 8'h6E, 8'h48, 8'h2C, 8'hA8, 8'h75,
        8'hB1, 8'h0A, 8'hAE, 8'h9F, 8'h27, 8'h80, 8'h10, 8'hCE,
        8'hF0, 8'h29, 8'h28, 8'h85, 8'h0D, 8'h05, 8'hF7, 8'h35,
        8'hBB, 8'hBC, 8'h15, 8'h06, 8'hF5, 8'h60, 8'h71, 8'h03,
        8'h1F, 8'hEA, 8'h5A, 8'h33, 8'h92, 8'h8D, 8'hE7, 8'h90,
        8'h5B, 8'hE9, 8'hCF, 8'h9E, 8'hD3, 8'h5D, 8'hED, 8'h31,
        8'h1C, 8'h0B, 8'h52, 8'h16, 8'h51, 8'h0F, 8'h86, 8'hC5,
        8'h68, 8'h9B, 8'h21, 8'h0C, 8'h8B, 8'h42, 8'h87, 8'hFF,
        8'h4F, 8'hBE, 8'hC8, 8'hE8, 8'hC7, 8'hD4, 8'h7A, 8'hE0,
        8'h55, 8'h2F, 8'h8A, 8'h8E, 8'hBA, 8'h98, 8'h37, 8'hE4,
        8'hB2, 8'h38, 8'hA1, 8'hB6, 8'h32, 8'h83, 8'h3A, 8'h7B,
        8'h84, 8'h3C, 8'h61, 8'hFB, 8'h8C, 8'h14, 8'h3D, 8'h43,
        8'h3B, 8'h1D, 8'hC3, 8'hA2, 8'h96, 8'hB3, 8'hF8, 8'hC4,
        8'hF2, 8'h26, 8'h2B, 8'hD8, 8'h7C, 8'hFC, 8'h23, 8'h24,
        8'h66, 8'hEF, 8'h69, 8'h64, 8'h50, 8'h54, 8'h59, 8'hF1,
        8'hA0, 8'h74, 8'hAC, 8'hC6, 8'h7D, 8'hB5, 8'hE6, 8'hE2,
        8'hC2, 8'h7E, 8'h67, 8'h17, 8'h5E, 8'hE1, 8'hB9, 8'h3F,
        8'h6C, 8'h70, 8'h08, 8'h99, 8'h45, 8'h56, 8'h76, 8'hF9,
        8'h9A, 8'h97, 8'h19, 8'h72, 8'h5C, 8'h02, 8'h8F, 8'h58
    };

    function automatic logic [7:0] sbox_lookup(input logic [7:0] idx);
        return SBOX_TABLE[idx];
    endfunction

endpackage

>>> rtl/core/pxsd_in_if.sv
// Input word channel
interface pxsd_in_if import pxsd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/pxsd_out_if.sv
// Result word channel
interface pxsd_out_if import pxsd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/packet_xor_sbox_descrambler_unit.sv
// Packet descrambler: takes one byte word per cycle on i_word when not stalled and returns
// one result word per input word on o_word through the input and output registers;
// sustained rate is one word per clock when the output is not stalled, set by the input
// register, the combinational XOR/substitution/checksum path and the output register. The
// first word of a packet carries the expected checksum and yields a result with out_valid
// low; the key is the low byte of port XOR KEY_MASK on that word. checksum_ok is meaningful
// only with packet_end. Packets have no length limit.
module packet_xor_sbox_descrambler_unit import pxsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pxsd_in_if.sink     i_word,
    pxsd_out_if.source  o_word
);

    logic      r_s1_valid;
    t_in_word  r_s1_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      n_s1_valid;
    logic      n_out_valid;

    logic      w_out_ready;
    logic      w_advance;
    t_out_word w_result;

    // Handshake: output register frees up when empty or taken
    assign w_out_ready  = !r_out_valid || o_word.ready;
    assign w_advance    = r_s1_valid && w_out_ready;
    assign i_word.ready = !r_s1_valid || w_advance;

    assign o_word.valid   = r_out_valid;
    assign o_word.payload = r_out_word;

    pxsd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_word    (r_s1_word),
        .o_result  (w_result)
    );

    // Next occupancy of both stages
    always_comb begin
        n_s1_valid  = i_word.ready ? i_word.valid : r_s1_valid;
        n_out_valid = w_out_ready ? r_s1_valid : r_out_valid;
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_word.valid && i_word.ready) begin
            r_s1_word <= i_word.payload;
        end
        if (w_advance) begin
            r_out_word <= w_result;
        end
    end

    // Checks
    a_ok_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.checksum_ok |-> r_out_word.packet_end)
        else $error("checksum_ok without packet_end");

    a_no_byte_on_checksum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_word.out_valid |-> r_out_word.out_byte == 8'h00)
        else $error("nonzero byte on checksum word result");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !o_word.ready |-> !i_word.ready)
        else $error("input accepted while both stages are full");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_advance |=> r_s1_valid && $stable(r_s1_word))
        else $error("held word lost from input register");

endmodule

>>> rtl/core/pxsd_core.sv
// Per-packet descramble state and the result of one word.
// State moves on only when i_advance is high.
module pxsd_core import pxsd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_word  i_word,
    output t_out_word o_result
);

    logic [7:0] r_key;
    logic       r_odd;
    logic [7:0] r_sum;
    logic [7:0] r_expected;

    logic [7:0] n_key;
    logic       n_odd;
    logic [7:0] n_sum;
    logic [7:0] n_expected;

    logic [7:0] w_mixed;
    logic [7:0] w_sub;

    // XOR with key on odd positions, then substitute
    assign w_mixed = r_odd ? (i_word.in_byte ^ r_key) : i_word.in_byte;
    assign w_sub   = sbox_lookup(w_mixed);

    // Next state and result
    always_comb begin
        if (i_word.first_of_packet) begin
            n_key      = i_word.port[7:0] ^ KEY_MASK;
            n_odd      = 1'b0;
            n_sum      = 8'h00;
            n_expected = i_word.in_byte;
            o_result.out_byte  = 8'h00;
            o_result.out_valid = 1'b0;
        end else begin
            n_key      = r_key;
            n_odd      = ~r_odd;
            n_sum      = r_sum ^ (w_sub & SUM_MASK);
            n_expected = r_expected;
            o_result.out_byte  = w_sub;
            o_result.out_valid = 1'b1;
        end
        o_result.packet_end  = i_word.last_of_packet;
        o_result.checksum_ok = i_word.last_of_packet && (n_sum == n_expected);
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= 8'h00;
            r_odd      <= 1'b0;
            r_sum      <= 8'h00;
            r_expected <= 8'h00;
        end else if (i_advance) begin
            r_key      <= n_key;
            r_odd      <= n_odd;
            r_sum      <= n_sum;
            r_expected <= n_expected;
        end
    end

endmodule
